### rtl/plt_pkg.sv
// Shared types, function codes and colour arithmetic for the RGB565 palette fade engine.
// Depends on nothing; plt_seq and the top level refer to it by scoped names.
`default_nettype none

package plt_pkg;

  localparam logic [2:0] FN_LOAD         = 3'd0;
  localparam logic [2:0] FN_SNAPSHOT     = 3'd1;
  localparam logic [2:0] FN_FADE_BEGIN   = 3'd2;
  localparam logic [2:0] FN_FADE_STEP    = 3'd3;
  localparam logic [2:0] FN_UNFADE_BEGIN = 3'd4;
  localparam logic [2:0] FN_UNFADE_STEP  = 3'd5;
  localparam logic [2:0] FN_READ         = 3'd6;

  localparam logic [5:0] LEVEL_MAX = 6'd32;
  localparam logic [4:0] FADE_RB   = 5'd2;
  localparam logic [5:0] FADE_G    = 6'd4;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] color_565;
    logic        warning;
  } out_beat_t;

  typedef struct packed {
    logic       clr;
    logic       idle;
    logic       rd;
    logic       sweep_rd;
    logic       sweep_wr;
    logic       fin;
    logic [2:0] op;
  } seq_ctl_t;

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] fade565(input logic [15:0] p);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = (p[15:11] > FADE_RB) ? p[15:11] - FADE_RB : 5'd0;
    g = (p[10:5] > FADE_G) ? p[10:5] - FADE_G : 6'd0;
    b = (p[4:0] > FADE_RB) ? p[4:0] - FADE_RB : 5'd0;
    return {r, g, b};
  endfunction

  function automatic logic [15:0] unfade565(input logic [15:0] s, input logic [5:0] level);
    logic [6:0] lv2;
    logic [7:0] lv4;
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    lv2 = {level, 1'b0};
    lv4 = {level, 2'b00};
    r = (lv2 < {2'b00, s[15:11]}) ? lv2[4:0] : s[15:11];
    g = (lv4 < {2'b00, s[10:5]}) ? lv4[5:0] : s[10:5];
    b = (lv2 < {2'b00, s[4:0]}) ? lv2[4:0] : s[4:0];
    return {r, g, b};
  endfunction

endpackage

`default_nettype wire

### rtl/plt_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing; used twice by the fade engine top level.
`default_nettype none

module plt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/plt_seq.sv
// Sequencer of the fade engine: state machine, entry counter and the write stage of a sweep.
// Depends on plt_pkg for the function codes and the control struct.
`default_nettype none

module plt_seq #(
  parameter int ENTRIES = 256,
  localparam int AW = $clog2(ENTRIES),
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic [2:0]       in_func,
  input  wire logic             out_free,
  output plt_pkg::seq_ctl_t     ctl,
  output logic      [AW-1:0]    raddr,
  output logic      [AW-1:0]    waddr
);

  typedef enum logic [4:0] {
    ST_CLR   = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RD    = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    op_r, op_nxt;
  logic          wv_r;
  logic [AW-1:0] wa_r;
  logic          issuing;

  assign issuing = (state_r == ST_SWEEP) && (cnt_r != CW'(ENTRIES));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_func;
          cnt_nxt = '0;
          if (in_func == plt_pkg::FN_READ) begin
            state_nxt = ST_RD;
          end else if (in_func == plt_pkg::FN_SNAPSHOT || in_func == plt_pkg::FN_FADE_BEGIN ||
                       in_func == plt_pkg::FN_FADE_STEP || in_func == plt_pkg::FN_UNFADE_STEP) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_FIN;
      end
      ST_SWEEP: begin
        if (issuing) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!wv_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r   <= '0;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wv_r    <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    wa_r <= cnt_r[AW-1:0];
  end

  assign ctl.clr      = (state_r == ST_CLR);
  assign ctl.idle     = (state_r == ST_IDLE);
  assign ctl.rd       = (state_r == ST_RD);
  assign ctl.sweep_rd = issuing;
  assign ctl.sweep_wr = wv_r;
  assign ctl.fin      = (state_r == ST_FIN);
  assign ctl.op       = op_r;

  assign raddr = cnt_r[AW-1:0];
  assign waddr = (state_r == ST_CLR) ? cnt_r[AW-1:0] : wa_r;

endmodule

`default_nettype wire

### rtl/palette_565_fade_engine_core.sv
// Top level of the RGB565 palette fade engine: palette and saved-copy RAMs, colour datapath,
// faded flag, unfade level and the result register. Depends on plt_pkg, plt_ram and plt_seq.
`default_nettype none

// After reset the block clears both RAMs, one entry per cycle, before it raises in_ready.
// For load, unfade begin and the unused code the sequencer goes to its finish state, from
// which out_valid is registered once the output is free. For read it first passes a read
// state, as the palette RAM has registered read data. Snapshot, fade begin, fade step and
// unfade step sweep every entry through a read, modify and write-back over the RAM ports
// before the finish state. One beat is handled at a time. in_ready returns at the edge that
// loads the result register, so a result beat can wait there while the next beat is accepted.
module palette_565_fade_engine_core #(
  parameter int ENTRIES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire plt_pkg::in_beat_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output plt_pkg::out_beat_t       out_data
);

  localparam int AW = $clog2(ENTRIES);

  plt_pkg::seq_ctl_t  ctl;
  logic [AW-1:0]      raddr, waddr;
  logic               in_fire, out_free;
  logic [31:0]        idx_v;
  logic [AW-1:0]      idx;
  logic [15:0]        packed_col;

  logic               p_we, p_re, s_we, s_re;
  logic [AW-1:0]      p_waddr, p_raddr;
  logic [15:0]        p_wdata, s_wdata, p_rdata, s_rdata;

  logic               flag_r, flag_nxt;
  logic [5:0]         level_r, level_nxt;
  plt_pkg::out_beat_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  plt_pkg::out_beat_t out_data_r, out_data_nxt;

  assign in_ready   = ctl.idle;
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign packed_col = plt_pkg::pack565(in_data.red, in_data.green, in_data.blue);

  always_comb begin
    idx_v = 32'(in_data.index);
    for (int k = 7; k >= 0; k--) begin
      if (idx_v >= (32'(ENTRIES) << k)) begin
        idx_v = idx_v - (32'(ENTRIES) << k);
      end
    end
    idx = idx_v[AW-1:0];
  end

  plt_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_func  (in_data.func),
    .out_free (out_free),
    .ctl      (ctl),
    .raddr    (raddr),
    .waddr    (waddr)
  );

  assign p_we = ctl.clr || (in_fire && in_data.func == plt_pkg::FN_LOAD) ||
                (ctl.sweep_wr && (ctl.op == plt_pkg::FN_FADE_STEP ||
                                  ctl.op == plt_pkg::FN_UNFADE_STEP));
  assign p_waddr = in_fire ? idx : waddr;
  assign p_re = (in_fire && in_data.func == plt_pkg::FN_READ) ||
                (ctl.sweep_rd && ctl.op != plt_pkg::FN_UNFADE_STEP);
  assign p_raddr = in_fire ? idx : raddr;

  assign s_we = ctl.clr || (ctl.sweep_wr && (ctl.op == plt_pkg::FN_SNAPSHOT ||
                                             ctl.op == plt_pkg::FN_FADE_BEGIN));
  assign s_re    = ctl.sweep_rd && ctl.op == plt_pkg::FN_UNFADE_STEP;
  assign s_wdata = ctl.clr ? 16'd0 : p_rdata;

  always_comb begin
    priority if (ctl.clr) begin
      p_wdata = 16'd0;
    end else if (in_fire) begin
      p_wdata = packed_col;
    end else if (ctl.op == plt_pkg::FN_FADE_STEP) begin
      p_wdata = plt_pkg::fade565(p_rdata);
    end else begin
      p_wdata = plt_pkg::unfade565(s_rdata, level_r);
    end
  end

  plt_ram #(.DEPTH(ENTRIES), .WIDTH(16)) u_pal (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  plt_ram #(.DEPTH(ENTRIES), .WIDTH(16)) u_sav (
    .clk   (clk),
    .we    (s_we),
    .waddr (waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (raddr),
    .rdata (s_rdata)
  );

  always_comb begin
    flag_nxt  = flag_r;
    level_nxt = level_r;
    res_nxt   = res_r;
    if (in_fire) begin
      res_nxt = '0;
      unique case (in_data.func)
        plt_pkg::FN_LOAD: begin
          res_nxt.color_565 = packed_col;
        end
        plt_pkg::FN_SNAPSHOT: begin
          flag_nxt = 1'b1;
        end
        plt_pkg::FN_FADE_BEGIN: begin
          res_nxt.warning = flag_r;
          flag_nxt        = 1'b1;
        end
        plt_pkg::FN_UNFADE_BEGIN: begin
          res_nxt.warning = !flag_r;
          level_nxt       = '0;
        end
        plt_pkg::FN_UNFADE_STEP: begin
          if (level_r < plt_pkg::LEVEL_MAX) begin
            level_nxt = level_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (ctl.rd) begin
      res_nxt.color_565 = p_rdata;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctl.fin && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= 1'b0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      flag_r      <= flag_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= plt_pkg::LEVEL_MAX)
    else $error("unfade level beyond its limit");

  a_one_store: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.clr |-> !(p_we && s_we))
    else $error("both stores written outside the clearing pass");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.fin))
    else $error("result beat raised without a finished item");

  a_wb_trails: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.sweep_wr |-> $past(ctl.sweep_rd) && (waddr == $past(raddr)))
    else $error("sweep write-back does not follow its read");
`endif

endmodule

`default_nettype wire

### tb/sv/palette_565_fade_engine_core_tb.sv
// Self-checking testbench for palette_565_fade_engine_core: directed and random command beats,
// with a scoreboard class that tracks both palettes, the faded flag and the unfade level.
// Depends on plt_pkg and the RTL of palette_565_fade_engine_core.
`default_nettype none

module palette_565_fade_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 256;
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int BEAT_TARGET = 1550;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SIDE_IN = 0;
  localparam int SIDE_OUT = 1;

  class palette_tracker;
    logic [15:0] palette_mem [ENTRIES];
    logic [15:0] saved_mem [ENTRIES];
    bit faded;
    int level;
    plt_pkg::out_beat_t predicted[$];
    int errors;

    function new();
      int i;
      for (i = 0; i < ENTRIES; i++) begin
        palette_mem[i] = '0;
        saved_mem[i] = '0;
      end
      faded = 1'b0;
      level = 0;
      errors = 0;
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    function void note_command(plt_pkg::in_beat_t b);
      plt_pkg::out_beat_t res;
      logic [15:0] p;
      int i;
      int r;
      int g;
      int bl;
      res = '0;
      case (b.func)
        plt_pkg::FN_LOAD: begin
          p = {b.red[7:3], b.green[7:2], b.blue[7:3]};
          palette_mem[b.index] = p;
          res.color_565 = p;
        end
        plt_pkg::FN_SNAPSHOT, plt_pkg::FN_FADE_BEGIN: begin
          res.warning = (b.func == plt_pkg::FN_FADE_BEGIN) && faded;
          for (i = 0; i < ENTRIES; i++) saved_mem[i] = palette_mem[i];
          faded = 1'b1;
        end
        plt_pkg::FN_FADE_STEP: begin
          for (i = 0; i < ENTRIES; i++) begin
            p = palette_mem[i];
            r = p[15:11];
            g = p[10:5];
            bl = p[4:0];
            r = (r > plt_pkg::FADE_RB) ? r - plt_pkg::FADE_RB : 0;
            g = (g > plt_pkg::FADE_G) ? g - plt_pkg::FADE_G : 0;
            bl = (bl > plt_pkg::FADE_RB) ? bl - plt_pkg::FADE_RB : 0;
            palette_mem[i] = {r[4:0], g[5:0], bl[4:0]};
          end
        end
        plt_pkg::FN_UNFADE_BEGIN: begin
          res.warning = !faded;
          level = 0;
        end
        plt_pkg::FN_UNFADE_STEP: begin
          if (level < plt_pkg::LEVEL_MAX) level++;
          for (i = 0; i < ENTRIES; i++) begin
            p = saved_mem[i];
            r = (level * 2 < p[15:11]) ? level * 2 : p[15:11];
            g = (level * 4 < p[10:5]) ? level * 4 : p[10:5];
            bl = (level * 2 < p[4:0]) ? level * 2 : p[4:0];
            palette_mem[i] = {r[4:0], g[5:0], bl[4:0]};
          end
        end
        plt_pkg::FN_READ: begin
          res.color_565 = palette_mem[b.index];
        end
        default: begin
        end
      endcase
      predicted.push_back(res);
    endfunction

    function void check_result(plt_pkg::out_beat_t got);
      plt_pkg::out_beat_t want;
      if (predicted.size() == 0) begin
        errors++;
        $error("result beat with nothing expected: color_565 0x%04h, warning %b",
               got.color_565, got.warning);
        return;
      end
      want = predicted.pop_front();
      if (got.color_565 !== want.color_565) begin
        errors++;
        $error("color_565: expected 0x%04h, got 0x%04h", want.color_565, got.color_565);
      end
      if (got.warning !== want.warning) begin
        errors++;
        $error("warning: expected %b, got %b", want.warning, got.warning);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  plt_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  plt_pkg::out_beat_t out_data;

  palette_tracker tracker = new();
  int beats_sent = 0;
  int cycle_count = 0;
  int calm_left [2] = '{0, 0};

  palette_565_fade_engine_core #(.ENTRIES(ENTRIES)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left[side] = $urandom_range(10, 60);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] pick_index();
    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic plt_pkg::in_beat_t make_beat(input logic [2:0] f, input logic [7:0] idx,
                                                  input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
    plt_pkg::in_beat_t beat;
    beat.func = f;
    beat.index = idx;
    beat.red = r;
    beat.green = g;
    beat.blue = b;
    return beat;
  endfunction

  function automatic plt_pkg::in_beat_t random_beat(input logic [2:0] f);
    return make_beat(f, pick_index(), pick_channel(), pick_channel(), pick_channel());
  endfunction

  function automatic int step_count(input int longest);
    return ($urandom_range(0, 7) == 0) ? longest : $urandom_range(1, 5);
  endfunction

  task automatic send_beat(input plt_pkg::in_beat_t b);
    int gap;
    gap = draw_wait(SIDE_IN);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_command(b);
    beats_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  task automatic run_fade_cycle();
    repeat ($urandom_range(1, 6)) send_beat(random_beat(plt_pkg::FN_LOAD));
    send_beat(random_beat(($urandom_range(0, 1) != 0) ? plt_pkg::FN_FADE_BEGIN :
                                                        plt_pkg::FN_SNAPSHOT));
    repeat (step_count(17)) send_beat(random_beat(plt_pkg::FN_FADE_STEP));
    repeat ($urandom_range(1, 3)) send_beat(random_beat(plt_pkg::FN_READ));
    send_beat(random_beat(plt_pkg::FN_UNFADE_BEGIN));
    repeat (step_count(34)) send_beat(random_beat(plt_pkg::FN_UNFADE_STEP));
    repeat ($urandom_range(1, 3)) send_beat(random_beat(plt_pkg::FN_READ));
  endtask

  initial begin
    int stall;
    forever begin
      stall = draw_wait(SIDE_OUT);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_data);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unfade begin before any snapshot or fade begin is the only way to see its warning.
    send_beat(make_beat(plt_pkg::FN_READ, 8'h00, 8'hff, 8'hff, 8'hff));
    send_beat(make_beat(plt_pkg::FN_UNFADE_BEGIN, 8'hff, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(FN_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff));
    send_beat(make_beat(plt_pkg::FN_UNFADE_STEP, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_LOAD, 8'h00, 8'hff, 8'hff, 8'hff));
    send_beat(make_beat(plt_pkg::FN_LOAD, 8'hff, 8'hff, 8'h00, 8'hff));
    send_beat(make_beat(plt_pkg::FN_LOAD, 8'h01, 8'h00, 8'hff, 8'h00));
    send_beat(make_beat(plt_pkg::FN_LOAD, 8'h02, 8'h08, 8'h04, 8'h08));
    send_beat(make_beat(plt_pkg::FN_LOAD, 8'h03, 8'h10, 8'h0c, 8'h18));
    send_beat(make_beat(plt_pkg::FN_FADE_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_FADE_STEP, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_FADE_STEP, 8'hff, 8'hff, 8'hff, 8'hff));
    send_beat(make_beat(plt_pkg::FN_READ, 8'h02, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_READ, 8'h03, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_UNFADE_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_UNFADE_STEP, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_UNFADE_STEP, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_SNAPSHOT, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_FADE_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(plt_pkg::FN_READ, 8'hff, 8'h00, 8'h00, 8'h00));
    send_beat(make_beat(FN_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_for_results();

    while (beats_sent < BEAT_TARGET) begin
      if ($urandom_range(0, 3) != 0) begin
        run_fade_cycle();
      end else begin
        repeat ($urandom_range(1, 8)) send_beat(random_beat(3'($urandom_range(0, 7))));
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (ENTRIES + 16) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
